/* hdl/lfs_pkg.sv */
// lfs_pkg: types and constants shared by the link failover selector
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package lfs_pkg;

   localparam int unsigned MAX_DEVICES = 8;
   localparam int unsigned DEV_W       = $clog2(MAX_DEVICES);
   localparam int unsigned DCOUNT_W    = 4;
   localparam int unsigned CODE_W      = 8;
   localparam int unsigned ECOUNT_W    = 16;
   localparam int unsigned TIMEOUT_W   = 16;
   localparam int unsigned SILENCE_W   = 32;
   localparam int unsigned MASK_W      = 8;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CODE_W-1:0]    NO_LINK_CODE      = 8'h09;
   localparam logic [DCOUNT_W-1:0]  DEVICE_COUNT_RST  = 4'd2;
   localparam logic [TIMEOUT_W-1:0] ERROR_TIMEOUT_RST = 16'd100;
   localparam logic [MASK_W-1:0]    ENABLES_RST       = 8'h01;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_TIMEOUT = 1'd1;

   typedef enum logic [1:0] {
      LINK_WATCH   = 2'd0,
      LINK_SWITCH  = 2'd1,
      LINK_RESTORE = 2'd2
   } link_state_type;

   typedef enum logic [5:0] {
      SEQ_IDLE    = 6'b000001,
      SEQ_REPORT  = 6'b000010,
      SEQ_TIMER   = 6'b000100,
      SEQ_READ    = 6'b001000,
      SEQ_CHECK   = 6'b010000,
      SEQ_RESPOND = 6'b100000
   } seq_state_type;

   typedef struct packed {
      logic                en;
      logic [DEV_W-1:0]    addr;
      logic [CODE_W-1:0]   code;
      logic [ECOUNT_W-1:0] count;
   } tbl_wr_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [ECOUNT_W-1:0] count;
   } tbl_entry_type;

endpackage

`default_nettype wire

/* hdl/lfs_if.sv */
// lfs_req_if / lfs_rsp_if: valid/ready channels of the link failover selector
// depends on lfs_pkg for field widths
`default_nettype none

interface lfs_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic                             hold;
   logic                             connect;
   logic [lfs_pkg::DEV_W-1:0]        device;
   logic [lfs_pkg::CODE_W-1:0]       err_code;
   logic [lfs_pkg::ECOUNT_W-1:0]     err_count;

   modport source (output valid, func, hold, connect, device, err_code, err_count,
                   input ready);
   modport sink   (input valid, func, hold, connect, device, err_code, err_count,
                   output ready);
endinterface

interface lfs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lfs_pkg::MASK_W-1:0]       enable_mask;
   logic [lfs_pkg::DEV_W-1:0]        active_device;
   logic                             count_enable;
   logic                             connect_error;
   logic [lfs_pkg::SILENCE_W-1:0]    silence_time;

   modport source (output valid, enable_mask, active_device, count_enable,
                   connect_error, silence_time, input ready);
   modport sink   (input valid, enable_mask, active_device, count_enable,
                   connect_error, silence_time, output ready);
endinterface

`default_nettype wire

/* hdl/lfs_err_table.sv */
// lfs_err_table: per-device error code and count store, one write and one
// registered read per cycle; depends on lfs_pkg
`default_nettype none

module lfs_err_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lfs_pkg::tbl_wr_type           wr,
   input  wire logic [lfs_pkg::DEV_W-1:0]     rd_addr,
   output lfs_pkg::tbl_entry_type             rd_data
);

   lfs_pkg::tbl_entry_type                  mem [lfs_pkg::MAX_DEVICES];
   logic [lfs_pkg::MAX_DEVICES-1:0]         valid_ff;
   lfs_pkg::tbl_entry_type                  rd_entry_ff;
   logic                                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= '{code: wr.code, count: wr.count};
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_entry_ff : '0;

endmodule

`default_nettype wire

/* hdl/lfs_timeout_cmp.sv */
// lfs_timeout_cmp: shared timeout compare, used for the watch check and
// for every step of the switch scan; depends on lfs_pkg
`default_nettype none

module lfs_timeout_cmp (
   input  wire lfs_pkg::tbl_entry_type            entry,
   input  wire logic [lfs_pkg::TIMEOUT_W-1:0]     timeout,
   output logic                                   timed_out
);

   assign timed_out = (entry.code == lfs_pkg::NO_LINK_CODE) &&
                      (entry.count >= timeout);

endmodule

`default_nettype wire

/* hdl/link_failover_selector_core.sv */
// link_failover_selector_core: top level, sequencer and link state
// depends on lfs_pkg, lfs_if, lfs_err_table and lfs_timeout_cmp
//
// Usage: requests arrive on req_ch (valid/ready). func = 1 stores an error
// code and count for one device; func = 0 is a tick that runs the silence
// timer and one step of the watch/switch/restore machine unless hold is set.
// Each request gives exactly one response on rsp_ch with the enable mask,
// active device, count enable, connect error and silence time after it.
// From acceptance to response valid, a held tick goes straight to RESPOND,
// a report passes REPORT, a restore tick passes TIMER, a watch tick passes
// TIMER, READ and CHECK, and a switch tick that scans k devices (k up to the
// device count, at most 8) passes TIMER and then READ and CHECK per device,
// as the shared timeout compare checks one table entry per READ and CHECK.
// One request is worked on at a time; req_ch.ready is high only while idle.
// The response sits in an output register, so a new request is taken while
// the previous response still waits; a stalled receiver holds the next
// response back until the register frees.
// csr_* writes device_count (index 0) and error_timeout (index 1); the user
// writes them only while idle, not enforced. Synchronous reset: watch state,
// device 0 active and enabled, flags, timer, table zero, registers 2 and 100.
`default_nettype none

module link_failover_selector_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lfs_req_if.sink                                  req_ch,
   lfs_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_write_enable,
   input  wire logic [lfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lfs_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   lfs_pkg::seq_state_type                 seq_ff, seq_in;
   lfs_pkg::link_state_type                link_ff, link_in;

   logic [lfs_pkg::DCOUNT_W-1:0]           dev_count_ff;
   logic [lfs_pkg::TIMEOUT_W-1:0]          timeout_ff;

   logic                                   connect_ff;
   logic [lfs_pkg::DEV_W-1:0]              device_ff;
   logic [lfs_pkg::CODE_W-1:0]             code_ff;
   logic [lfs_pkg::ECOUNT_W-1:0]           count_ff;

   logic [lfs_pkg::DEV_W-1:0]              active_ff, active_in;
   logic [lfs_pkg::MASK_W-1:0]             enables_ff, enables_in;
   logic                                   cflag_ff, cflag_in;
   logic                                   prev_cflag_ff, prev_cflag_in;
   logic                                   fail_ff, fail_in;
   logic [lfs_pkg::SILENCE_W-1:0]          silence_ff, silence_in;
   logic [lfs_pkg::DEV_W-1:0]              scan_ff, scan_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [lfs_pkg::MASK_W-1:0]             rsp_mask_ff;
   logic [lfs_pkg::DEV_W-1:0]              rsp_active_ff;
   logic                                   rsp_cflag_ff, rsp_fail_ff;
   logic [lfs_pkg::SILENCE_W-1:0]          rsp_silence_ff;

   logic [lfs_pkg::DCOUNT_W-1:0]           used_n;
   logic [lfs_pkg::DCOUNT_W-1:0]           scan_next;
   logic [lfs_pkg::DCOUNT_W-1:0]           active_next;
   logic [lfs_pkg::SILENCE_W-1:0]          silence_base;
   logic                                   req_fire, rsp_load, timed_out;
   lfs_pkg::tbl_wr_type                    tbl_wr;
   lfs_pkg::tbl_entry_type                 tbl_rd;
   logic [lfs_pkg::DEV_W-1:0]              tbl_rd_addr;

   assign req_ch.ready = (seq_ff == lfs_pkg::SEQ_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_load     = (seq_ff == lfs_pkg::SEQ_RESPOND) && (!rsp_valid_ff || rsp_ch.ready);

   // device count clamped to 1..MAX_DEVICES
   always_comb begin
      if (dev_count_ff == '0) begin
         used_n = lfs_pkg::DCOUNT_W'(1);
      end else if (dev_count_ff > lfs_pkg::DCOUNT_W'(lfs_pkg::MAX_DEVICES)) begin
         used_n = lfs_pkg::DCOUNT_W'(lfs_pkg::MAX_DEVICES);
      end else begin
         used_n = dev_count_ff;
      end
   end

   assign scan_next   = {1'b0, scan_ff} + lfs_pkg::DCOUNT_W'(1);
   assign active_next = {1'b0, active_ff} + lfs_pkg::DCOUNT_W'(1);
   assign silence_base = (cflag_ff && !prev_cflag_ff) ? '0 : silence_ff;
   assign tbl_rd_addr  = (link_ff == lfs_pkg::LINK_SWITCH) ? scan_ff : active_ff;

   lfs_err_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd)
   );

   lfs_timeout_cmp u_cmp (
      .entry     (tbl_rd),
      .timeout   (timeout_ff),
      .timed_out (timed_out)
   );

   always_comb begin
      seq_in        = seq_ff;
      link_in       = link_ff;
      active_in     = active_ff;
      enables_in    = enables_ff;
      cflag_in      = cflag_ff;
      prev_cflag_in = prev_cflag_ff;
      fail_in       = fail_ff;
      silence_in    = silence_ff;
      scan_in       = scan_ff;
      tbl_wr        = '{en: 1'b0, addr: device_ff, code: code_ff, count: count_ff};

      case (seq_ff)
         lfs_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               if (req_ch.func) begin
                  seq_in = lfs_pkg::SEQ_REPORT;
               end else if (req_ch.hold) begin
                  seq_in = lfs_pkg::SEQ_RESPOND;
               end else begin
                  seq_in = lfs_pkg::SEQ_TIMER;
               end
            end
         end
         lfs_pkg::SEQ_REPORT: begin
            tbl_wr.en = 1'b1;
            seq_in    = lfs_pkg::SEQ_RESPOND;
         end
         lfs_pkg::SEQ_TIMER: begin
            if (cflag_ff && (silence_base != '1)) begin
               silence_in = silence_base + lfs_pkg::SILENCE_W'(1);
            end else begin
               silence_in = silence_base;
            end
            prev_cflag_in = cflag_ff;
            if ({1'b0, active_ff} >= used_n) begin
               active_in = '0;
            end
            scan_in = '0;
            case (link_ff)
               lfs_pkg::LINK_SWITCH: begin
                  seq_in = lfs_pkg::SEQ_READ;
               end
               lfs_pkg::LINK_RESTORE: begin
                  cflag_in = 1'b1;
                  fail_in  = 1'b1;
                  link_in  = lfs_pkg::LINK_WATCH;
                  seq_in   = lfs_pkg::SEQ_RESPOND;
               end
               default: begin
                  seq_in = lfs_pkg::SEQ_READ;
               end
            endcase
         end
         lfs_pkg::SEQ_READ: begin
            seq_in = lfs_pkg::SEQ_CHECK;
         end
         lfs_pkg::SEQ_CHECK: begin
            if (link_ff == lfs_pkg::LINK_SWITCH) begin
               if (timed_out) begin
                  // drop the timed-out device and hand over to the next one
                  tbl_wr     = '{en: 1'b1, addr: scan_ff, code: '0, count: '0};
                  enables_in = enables_ff & ~(lfs_pkg::MASK_W'(1) << scan_ff);
                  if (scan_next >= used_n) begin
                     enables_in = enables_in | lfs_pkg::MASK_W'(1);
                     active_in  = '0;
                  end else begin
                     enables_in = enables_in | (lfs_pkg::MASK_W'(1) << scan_next[lfs_pkg::DEV_W-1:0]);
                     active_in  = (active_next >= used_n) ? '0 : active_next[lfs_pkg::DEV_W-1:0];
                  end
                  link_in = lfs_pkg::LINK_RESTORE;
                  seq_in  = lfs_pkg::SEQ_RESPOND;
               end else if (scan_next >= used_n) begin
                  link_in = lfs_pkg::LINK_RESTORE;
                  seq_in  = lfs_pkg::SEQ_RESPOND;
               end else begin
                  scan_in = scan_next[lfs_pkg::DEV_W-1:0];
                  seq_in  = lfs_pkg::SEQ_READ;
               end
            end else begin
               if (timed_out) begin
                  link_in = lfs_pkg::LINK_SWITCH;
               end else if (connect_ff) begin
                  cflag_in = 1'b0;
                  fail_in  = 1'b0;
               end
               seq_in = lfs_pkg::SEQ_RESPOND;
            end
         end
         lfs_pkg::SEQ_RESPOND: begin
            if (rsp_load) begin
               seq_in = lfs_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = lfs_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= lfs_pkg::SEQ_IDLE;
         link_ff       <= lfs_pkg::LINK_WATCH;
         dev_count_ff  <= lfs_pkg::DEVICE_COUNT_RST;
         timeout_ff    <= lfs_pkg::ERROR_TIMEOUT_RST;
         active_ff     <= '0;
         enables_ff    <= lfs_pkg::ENABLES_RST;
         cflag_ff      <= 1'b0;
         prev_cflag_ff <= 1'b0;
         fail_ff       <= 1'b0;
         silence_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         link_ff       <= link_in;
         active_ff     <= active_in;
         enables_ff    <= enables_in;
         cflag_ff      <= cflag_in;
         prev_cflag_ff <= prev_cflag_in;
         fail_ff       <= fail_in;
         silence_ff    <= silence_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               lfs_pkg::CSR_DEVICE_COUNT: begin
                  dev_count_ff <= csr_write_data[lfs_pkg::DCOUNT_W-1:0];
               end
               lfs_pkg::CSR_ERROR_TIMEOUT: begin
                  timeout_ff <= csr_write_data[lfs_pkg::TIMEOUT_W-1:0];
               end
               default: begin
                  timeout_ff <= timeout_ff;
               end
            endcase
         end
      end
   end

   // request capture, scan index and response payload
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (req_fire) begin
         connect_ff <= req_ch.connect;
         device_ff  <= req_ch.device;
         code_ff    <= req_ch.err_code;
         count_ff   <= req_ch.err_count;
      end
      if (rsp_load) begin
         rsp_mask_ff    <= enables_ff;
         rsp_active_ff  <= active_ff;
         rsp_cflag_ff   <= cflag_ff;
         rsp_fail_ff    <= fail_ff;
         rsp_silence_ff <= silence_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.enable_mask   = rsp_mask_ff;
   assign rsp_ch.active_device = rsp_active_ff;
   assign rsp_ch.count_enable  = rsp_cflag_ff;
   assign rsp_ch.connect_error = rsp_fail_ff;
   assign rsp_ch.silence_time  = rsp_silence_ff;

endmodule

`default_nettype wire
